// ===== design/lpp_pkg.sv =====
// Shared types, constants and header/reorder functions for the LPCM payload packer.
package lpp_pkg;

  // Packet buffer size in bytes; the payload is sized to fit it.
  localparam int unsigned BUF_BYTES = 2048;
  localparam int unsigned HDR_BYTES = 14;
  // Room left for payload once the headers are taken out.
  localparam int unsigned DIV_DEND  = BUF_BYTES - 2 * HDR_BYTES;
  localparam int unsigned DIV_W     = $clog2(DIV_DEND + 1);
  localparam int unsigned CNT_W     = $clog2(DIV_W);
  // Largest subframe: 160 samples x 8 channels x 3 bytes = 3840.
  localparam int unsigned SF_W      = 12;
  localparam int unsigned LEN_W     = (DIV_W > SF_W) ? DIV_W : SF_W;
  localparam int unsigned GRP_MAX   = 12;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned QPTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned POS_W     = 5;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RATE = 2'd0;
  localparam cfg_idx_t CFG_CHAN = 2'd1;
  localparam cfg_idx_t CFG_WIDE = 2'd2;

  localparam logic [2:0] RATE_48K  = 3'd0;
  localparam logic [2:0] RATE_96K  = 3'd1;
  localparam logic [2:0] RATE_192K = 3'd2;
  localparam logic [2:0] RATE_44K  = 3'd3;
  localparam logic [2:0] RATE_88K  = 3'd4;
  localparam logic [2:0] RATE_176K = 3'd5;

  typedef struct packed {
    logic [2:0] rate_code;
    logic [3:0] channel_count;
    logic       wide_samples;
  } cfg_t;

  // Packet geometry from the subframe division.
  typedef struct packed {
    logic             busy;
    logic [4:0]       spp_lo;
    logic [LEN_W-1:0] len;
  } calc_t;

  // One completed group, payload already in output order.
  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] bytes;
    logic                    wide;
    logic                    hdr;
    logic [4:0]              fc;
    logic                    pend;
  } job_t;

  function automatic logic [7:0] rate_samples_f(logic [2:0] rc);
    logic [7:0] s;
    case (rc)
      RATE_96K, RATE_88K:   s = 8'd80;
      RATE_192K, RATE_176K: s = 8'd160;
      default:              s = 8'd40;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] rate_bits_f(logic [2:0] rc);
    logic [7:0] b;
    case (rc)
      RATE_96K:  b = 8'h10;
      RATE_192K: b = 8'h20;
      RATE_44K:  b = 8'h80;
      RATE_88K:  b = 8'h90;
      RATE_176K: b = 8'hA0;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] eff_ch_f(logic [3:0] cc);
    logic [3:0] e;
    if (cc == 4'd0) begin
      e = 4'd1;
    end else if (cc > 4'd8) begin
      e = 4'd8;
    end else begin
      e = cc;
    end
    return e;
  endfunction

  function automatic logic [SF_W-1:0] sf_bytes_f(cfg_t c);
    logic [SF_W-1:0] sc;
    sc = SF_W'(rate_samples_f(c.rate_code)) * SF_W'(eff_ch_f(c.channel_count));
    return c.wide_samples ? (sc + (sc << 1)) : (sc << 1);
  endfunction

  // 24-bit group: source byte for each output position.
  function automatic logic [3:0] wide_src_f(logic [3:0] i);
    logic [3:0] s;
    case (i)
      4'd0:    s = 4'd2;
      4'd1:    s = 4'd1;
      4'd2:    s = 4'd5;
      4'd3:    s = 4'd4;
      4'd4:    s = 4'd8;
      4'd5:    s = 4'd7;
      4'd6:    s = 4'd11;
      4'd7:    s = 4'd10;
      4'd8:    s = 4'd0;
      4'd9:    s = 4'd3;
      4'd10:   s = 4'd6;
      4'd11:   s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] hdr_byte_f(logic [3:0] i, logic [4:0] fc, cfg_t c);
    logic [7:0] b;
    case (i)
      4'd0:    b = 8'hA0;
      4'd1:    b = {3'd0, fc};
      4'd3:    b = 8'h0A;
      4'd5:    b = 8'h09;
      4'd7:    b = 8'h0F | (c.wide_samples ? 8'h20 : 8'h00);
      4'd8:    b = 8'h0F | rate_bits_f(c.rate_code);
      4'd10:   b = {4'd0, eff_ch_f(c.channel_count) - 4'd1};
      4'd11:   b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/lpp_in_if.sv =====
// Byte stream interface for incoming PCM data.
interface lpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pcm_byte;

  modport source (output valid, output pcm_byte, input ready);
  modport sink   (input valid, input pcm_byte, output ready);
endinterface

// ===== design/lpp_out_if.sv =====
// Byte stream interface for outgoing packet data.
interface lpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       packet_end;
  logic       run_end;

  modport source (output valid, output out_byte, output is_header, output packet_end,
                  output run_end, input ready);
  modport sink   (input valid, input out_byte, input is_header, input packet_end,
                  input run_end, output ready);
endinterface

// ===== design/lpp_spp_calc.sv =====
// Restoring divider: subframes per packet and payload length from the configuration.
module lpp_spp_calc
  import lpp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  cfg_t  cfg_i,
  output calc_t calc_o
);

  localparam logic [DIV_W-1:0] DEND_V = DIV_W'(DIV_DEND);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SF_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [4:0]       spp_q, spp_d;
  logic [LEN_W-1:0] len_q, len_d;

  logic [SF_W-1:0]  sf;
  logic [SF_W:0]    rem_sh;
  logic             ge;
  logic [SF_W:0]    rem_sub;
  logic [SF_W-1:0]  rem_nx;
  logic [DIV_W-1:0] quo_nx;

  always_comb begin
    sf      = sf_bytes_f(cfg_i);
    rem_sh  = {rem_q, DEND_V[cnt_q]};
    ge      = rem_sh >= {1'b0, sf};
    rem_sub = rem_sh - {1'b0, sf};
    rem_nx  = ge ? rem_sub[SF_W-1:0] : rem_sh[SF_W-1:0];
    quo_nx  = {quo_q[DIV_W-2:0], ge};

    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    spp_d  = spp_q;
    len_d  = len_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W - 1);
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = rem_nx;
      quo_d = quo_nx;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        // no whole subframe fits: one subframe per packet
        if (quo_nx == '0) begin
          spp_d = 5'd1;
          len_d = LEN_W'(sf);
        end else begin
          spp_d = quo_nx[4:0];
          len_d = LEN_W'(DIV_DEND) - LEN_W'(rem_nx);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIV_W - 1);
      rem_q  <= '0;
      quo_q  <= '0;
      spp_q  <= '0;
      len_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      spp_q  <= spp_d;
      len_q  <= len_d;
    end
  end

  assign calc_o = '{busy: busy_q, spp_lo: spp_q, len: len_q};

endmodule

// ===== design/lpp_front.sv =====
// Front end: collects PCM bytes into groups, tracks packet position, queues jobs.
module lpp_front
  import lpp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      restart_i,
  input  cfg_t      cfg_i,
  input  calc_t     calc_i,
  lpp_in_if.sink    pcm_i,
  input  logic      full_i,
  output logic      push_o,
  output job_t      job_o
);

  logic [3:0]       fill_q, fill_d;
  logic [LEN_W-1:0] pcnt_q, pcnt_d;
  logic [4:0]       fc_q, fc_d;
  logic             hdr_pend_q, hdr_pend_d;
  logic [7:0]       store_q [GRP_MAX-1];

  logic                    acc;
  logic [3:0]              last_idx;
  logic                    grp_done;
  logic [LEN_W:0]          pcnt_sum;
  logic                    pend;
  logic [4:0]              fc_new;
  logic [GRP_MAX-1:0][7:0] grp;
  logic [GRP_MAX-1:0][7:0] ordered;

  assign pcm_i.ready = !calc_i.busy && !full_i;
  assign acc         = pcm_i.valid && pcm_i.ready;
  assign last_idx    = cfg_i.wide_samples ? 4'd11 : 4'd1;
  assign grp_done    = acc && (fill_q == last_idx);

  // Packet ends always fall on a group boundary (payload length is a group multiple).
  assign pcnt_sum = {1'b0, pcnt_q} + (LEN_W + 1)'(cfg_i.wide_samples ? 4'd12 : 4'd2);
  assign pend     = pcnt_sum >= {1'b0, calc_i.len};
  assign fc_new   = fc_q + calc_i.spp_lo;

  always_comb begin
    for (int i = 0; i < GRP_MAX - 1; i++) begin
      grp[i] = store_q[i];
    end
    grp[GRP_MAX-1] = pcm_i.pcm_byte;
    for (int i = 0; i < GRP_MAX; i++) begin
      ordered[i] = grp[wide_src_f(4'(i))];
    end
    if (!cfg_i.wide_samples) begin
      ordered    = '0;
      ordered[0] = pcm_i.pcm_byte;
      ordered[1] = store_q[0];
    end
  end

  always_comb begin
    fill_d     = fill_q;
    pcnt_d     = pcnt_q;
    fc_d       = fc_q;
    hdr_pend_d = hdr_pend_q;
    if (restart_i) begin
      fill_d     = '0;
      pcnt_d     = '0;
      fc_d       = '0;
      hdr_pend_d = 1'b1;
    end else if (grp_done) begin
      fill_d     = '0;
      pcnt_d     = pend ? '0 : pcnt_sum[LEN_W-1:0];
      hdr_pend_d = pend;
      if (hdr_pend_q) begin
        fc_d = fc_new;
      end
    end else if (acc) begin
      fill_d = fill_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pcnt_q     <= '0;
      fc_q       <= '0;
      hdr_pend_q <= 1'b1;
    end else begin
      fill_q     <= fill_d;
      pcnt_q     <= pcnt_d;
      fc_q       <= fc_d;
      hdr_pend_q <= hdr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !grp_done) begin
      store_q[fill_q] <= pcm_i.pcm_byte;
    end
  end

  assign push_o = grp_done;
  assign job_o  = '{bytes: ordered, wide: cfg_i.wide_samples, hdr: hdr_pend_q,
                    fc: fc_new, pend: pend};

endmodule

// ===== design/lpp_job_queue.sv =====
// Two-entry queue of group jobs between front and back end.
module lpp_job_queue
  import lpp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t              mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (QPTR_W + 1)'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

endmodule

// ===== design/lpp_back.sv =====
// Back end: plays out header and payload bytes of each job through an output register.
module lpp_back
  import lpp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  lpp_out_if.source  pkt_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             ov_q;
  logic [7:0]       byte_q;
  logic             hdr_q, pend_q, rend_q;

  logic             adv;
  logic             in_hdr;
  logic [POS_W-1:0] pidx;
  logic             last;
  logic [7:0]       nx_byte;

  assign adv    = job_valid_i && (!ov_q || pkt_o.ready);
  assign in_hdr = job_i.hdr && (pos_q < POS_W'(HDR_BYTES));
  assign pidx   = pos_q - (job_i.hdr ? POS_W'(HDR_BYTES) : POS_W'(0));
  assign last   = !in_hdr && (pidx[3:0] == (job_i.wide ? 4'd11 : 4'd1));
  assign nx_byte = in_hdr ? hdr_byte_f(pos_q[3:0], job_i.fc, cfg_i)
                          : job_i.bytes[pidx[3:0]];
  assign pos_d  = last ? '0 : pos_q + POS_W'(1);
  assign pop_o  = adv && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (adv) begin
        pos_q <= pos_d;
        ov_q  <= 1'b1;
      end else if (pkt_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= nx_byte;
      hdr_q  <= in_hdr;
      pend_q <= last && job_i.pend;
      rend_q <= last;
    end
  end

  assign pkt_o.valid      = ov_q;
  assign pkt_o.out_byte   = byte_q;
  assign pkt_o.is_header  = hdr_q;
  assign pkt_o.packet_end = pend_q;
  assign pkt_o.run_end    = rend_q;

endmodule

// ===== design/lpcm_payload_packer.sv =====
// Top level of the LPCM payload packer: config registers, front, queue, back.
//
//  Channel   Dir  Signals                                          Transfer when
//  pcm_i     in   valid, ready, pcm_byte[7:0]                      valid & ready
//  pkt_o     out  valid, ready, out_byte[7:0], is_header,          valid & ready
//                 packet_end, run_end
//  cfg       in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i[3:0]        cfg_we_i high
//
// The front takes one PCM byte per cycle while the job queue has room and the
// divider is idle; the back emits one packet byte per cycle while a job is queued
// and pkt_o is ready, so a 24-bit group with a header is a burst of 26 bytes.
// After reset and after every write to a known config register the payload length
// is recomputed by a restoring divider, one quotient bit per cycle; while it runs,
// pcm_i.ready is low.
// The output register holds its byte while pkt_o stalls and the back waits; the
// two-entry job queue lets the front keep collecting meanwhile.
module lpcm_payload_packer
  import lpp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_idx_t         cfg_idx_i,
  input  logic [3:0]       cfg_data_i,
  lpp_in_if.sink           pcm_i,
  lpp_out_if.source        pkt_o
);

  cfg_t  cfg_q, cfg_d;
  logic  restart;
  calc_t calc;
  logic  push, full, pop, job_valid;
  job_t  job_in, job_out;

  // Any write to a known register restarts packing; unknown indexes are dropped.
  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RATE: begin
          cfg_d.rate_code = cfg_data_i[2:0];
          restart         = 1'b1;
        end
        CFG_CHAN: begin
          cfg_d.channel_count = cfg_data_i;
          restart             = 1'b1;
        end
        CFG_WIDE: begin
          cfg_d.wide_samples = cfg_data_i[0];
          restart            = 1'b1;
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rate_code: RATE_48K, channel_count: 4'd2, wide_samples: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // subframes per packet and payload length
  lpp_spp_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (restart),
    .cfg_i   (cfg_q),
    .calc_o  (calc)
  );

  // grouping, packet position and frame counter
  lpp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .cfg_i     (cfg_q),
    .calc_i    (calc),
    .pcm_i     (pcm_i),
    .full_i    (full),
    .push_o    (push),
    .job_o     (job_in)
  );

  lpp_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  // byte playout: header then reordered payload
  lpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .pkt_o       (pkt_o)
  );

endmodule
